### rtl/vgm_pkg.sv
package vgm_pkg;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [3:0] code;
        logic [3:0] z;
        logic [3:0] y;
        logic [3:0] x;
    } req_t;

    // Lowest field last, so the packed struct matches the tdata layout.
    typedef struct packed {
        logic [15:0] vertex_base;
        logic [4:0]  span_second;
        logic [4:0]  span_first;
        logic [4:0]  origin_z;
        logic [4:0]  origin_y;
        logic [4:0]  origin_x;
        logic [3:0]  face_block;
        logic [1:0]  face_sign;
        logic [1:0]  quad_axis;
    } quad_t;

    localparam int QuadW = $bits(quad_t);
    localparam int OutDataW = ((QuadW + 7) / 8) * 8;

    localparam logic [1:0] SIGN_POS = 2'b01;
    localparam logic [1:0] SIGN_NEG = 2'b11;

    localparam logic [1:0] AXIS_X   = 2'd0;
    localparam logic [1:0] AXIS_Y   = 2'd1;
    localparam logic [1:0] AXIS_Z   = 2'd2;
    localparam logic [1:0] AXIS_END = 2'd3;

    localparam logic [15:0] VERTS_PER_QUAD = 16'd4;

    // Mask cell layout: face flag, negative-sign flag, block code.
    localparam int CELL_FACE_BIT = 5;
    localparam int CELL_NEG_BIT  = 4;

endpackage

### rtl/vgm_ram.sv
module vgm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/vgm_front.sv
module vgm_front
    import vgm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    output logic        q_valid,
    output req_t        q_item,
    input  logic        q_pop
);

    req_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    req_t       item_in;

    always_comb begin
        item_in.op   = op_t'(s_axis_tuser);
        item_in.x    = s_axis_tdata[3:0];
        item_in.y    = s_axis_tdata[7:4];
        item_in.z    = s_axis_tdata[11:8];
        item_in.code = s_axis_tdata[15:12];
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_item        = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (q_pop && q_valid) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !(q_pop && q_valid)) begin
            count_next = count_reg + 2'd1;
        end else if (!push && q_pop && q_valid) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

### rtl/vgm_back.sv
module vgm_back
    import vgm_pkg::*;
#(
    parameter int SIZE_X = 16,
    parameter int SIZE_Y = 16,
    parameter int SIZE_Z = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [3:0] cfg_wr_data,
    input  logic       q_valid,
    input  req_t       q_item,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output quad_t      m_quad,
    output logic       m_done
);

    localparam int SMAX_XY = (SIZE_X > SIZE_Y) ? SIZE_X : SIZE_Y;
    localparam int SMAX    = (SMAX_XY > SIZE_Z) ? SMAX_XY : SIZE_Z;
    localparam int CW      = $clog2(SMAX + 1);
    localparam int VD      = SIZE_X * SIZE_Y * SIZE_Z;
    localparam int VAW     = $clog2(VD);
    localparam int MXY     = SIZE_X * SIZE_Y;
    localparam int MYZ     = SIZE_Y * SIZE_Z;
    localparam int MZX     = SIZE_Z * SIZE_X;
    localparam int MD1     = (MXY > MYZ) ? MXY : MYZ;
    localparam int MD      = (MD1 > MZX) ? MD1 : MZX;
    localparam int MAW     = $clog2(MD);
    localparam int NW      = MAW + 1;

    localparam logic [CW-1:0] DIM_X = CW'(SIZE_X);
    localparam logic [CW-1:0] DIM_Y = CW'(SIZE_Y);
    localparam logic [CW-1:0] DIM_Z = CW'(SIZE_Z);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_B_CUR,
        ST_B_NXT,
        ST_B_WR,
        ST_SC_ISSUE,
        ST_SC_CHK,
        ST_W_ISSUE,
        ST_W_CHK,
        ST_H_ISSUE,
        ST_H_CHK,
        ST_CL,
        ST_NEXT,
        ST_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [1:0]      axis_reg, axis_next;
    logic [CW-1:0]   sp1_reg, sp1_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [CW-1:0]   i_reg, i_next;
    logic [CW-1:0]   j_reg, j_next;
    logic            mvalid_reg, mvalid_next;
    logic [15:0]     vcount_reg, vcount_next;
    logic [3:0]      air_reg;
    logic [5:0]      cell_reg, cell_next;
    logic [NW-1:0]   n0_reg, n0_next;
    logic [CW-1:0]   i0_reg, i0_next;
    logic [CW-1:0]   j0_reg, j0_next;
    logic [CW-1:0]   w_reg, w_next;
    logic [CW-1:0]   h_reg, h_next;
    logic [CW-1:0]   s_reg, s_next;
    logic [CW-1:0]   r_reg, r_next;
    logic [NW-1:0]   rb_reg, rb_next;
    logic [3:0]      cur_reg, cur_next;
    logic            fin_reg, fin_next;
    logic            out_valid_reg, out_valid_next;
    quad_t           out_quad_reg, out_quad_next;
    logic            out_done_reg, out_done_next;

    logic [CW-1:0]   l1, l2, dim_a;
    logic [NW-1:0]   total;
    logic [CW-1:0]   pa;
    logic [CW-1:0]   vx, vy, vz;
    logic [VAW-1:0]  vox_raddr, vox_waddr;
    logic            vox_we;
    logic [3:0]      vox_rdata;
    logic [MAW-1:0]  mask_raddr, mask_waddr;
    logic            mask_we;
    logic [5:0]      mask_wdata, mask_rdata;
    logic [3:0]      nxt_code;
    logic            cur_opaque, nxt_opaque;
    logic            wr_in_range;
    logic [CW:0]     i_ext_sum;
    logic [CW:0]     j_ext_sum;
    logic [CW-1:0]   ox, oy, oz;

    always_comb begin
        case (axis_reg)
            AXIS_X: begin
                l1 = DIM_Y; l2 = DIM_Z; dim_a = DIM_X; total = NW'(MYZ);
            end
            AXIS_Y: begin
                l1 = DIM_Z; l2 = DIM_X; dim_a = DIM_Y; total = NW'(MZX);
            end
            default: begin
                l1 = DIM_X; l2 = DIM_Y; dim_a = DIM_Z; total = NW'(MXY);
            end
        endcase
    end

    // The lower block of a boundary sits at slice, the upper one at slice + 1.
    assign pa = (state_reg == ST_B_CUR) ? (sp1_reg - CW'(1)) : sp1_reg;

    always_comb begin
        case (axis_reg)
            AXIS_X: begin
                vx = pa; vy = i_reg; vz = j_reg;
                ox = sp1_reg; oy = i0_reg; oz = j0_reg;
            end
            AXIS_Y: begin
                vy = pa; vz = i_reg; vx = j_reg;
                oy = sp1_reg; oz = i0_reg; ox = j0_reg;
            end
            default: begin
                vz = pa; vx = i_reg; vy = j_reg;
                oz = sp1_reg; ox = i0_reg; oy = j0_reg;
            end
        endcase
    end

    assign vox_raddr = VAW'((VAW'(vz) * VAW'(SIZE_Y) + VAW'(vy)) * VAW'(SIZE_X) + VAW'(vx));
    assign vox_waddr = VAW'((VAW'(q_item.z) * VAW'(SIZE_Y) + VAW'(q_item.y)) * VAW'(SIZE_X)
                            + VAW'(q_item.x));
    assign wr_in_range = (int'(q_item.x) < SIZE_X) && (int'(q_item.y) < SIZE_Y)
                         && (int'(q_item.z) < SIZE_Z);

    assign nxt_code   = (sp1_reg == dim_a) ? air_reg : vox_rdata;
    assign cur_opaque = (cur_reg != air_reg);
    assign nxt_opaque = (nxt_code != air_reg);
    assign i_ext_sum  = (CW+1)'(i0_reg) + (CW+1)'(w_reg);
    assign j_ext_sum  = (CW+1)'(j0_reg) + (CW+1)'(h_reg);

    vgm_ram #(.WIDTH(4), .DEPTH(VD)) u_voxel_ram (
        .aclk  (aclk),
        .we    (vox_we),
        .waddr (vox_waddr),
        .wdata (q_item.code),
        .raddr (vox_raddr),
        .rdata (vox_rdata)
    );

    vgm_ram #(.WIDTH(6), .DEPTH(MD)) u_mask_ram (
        .aclk  (aclk),
        .we    (mask_we),
        .waddr (mask_waddr),
        .wdata (mask_wdata),
        .raddr (mask_raddr),
        .rdata (mask_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        sp1_next       = sp1_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        mvalid_next    = mvalid_reg;
        vcount_next    = vcount_reg;
        cell_next      = cell_reg;
        n0_next        = n0_reg;
        i0_next        = i0_reg;
        j0_next        = j0_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        s_next         = s_reg;
        r_next         = r_reg;
        rb_next        = rb_reg;
        cur_next       = cur_reg;
        fin_next       = fin_reg;
        out_valid_next = out_valid_reg;
        out_quad_next  = out_quad_reg;
        out_done_next  = out_done_reg;
        q_pop          = 1'b0;
        vox_we         = 1'b0;
        mask_we        = 1'b0;
        mask_waddr     = n_reg[MAW-1:0];
        mask_wdata     = 6'd0;
        mask_raddr     = n_reg[MAW-1:0];

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.op == OP_WRITE) begin
                        if (wr_in_range) begin
                            vox_we      = 1'b1;
                            vcount_next = 16'd0;
                            axis_next   = AXIS_X;
                            sp1_next    = '0;
                            n_next      = '0;
                            i_next      = '0;
                            j_next      = '0;
                            mvalid_next = 1'b0;
                        end
                    end else if (axis_reg == AXIS_END) begin
                        fin_next   = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        fin_next   = 1'b0;
                        state_next = mvalid_reg ? ST_SC_ISSUE : ST_B_CUR;
                    end
                end
            end
            ST_B_CUR: begin
                state_next = ST_B_NXT;
            end
            ST_B_NXT: begin
                cur_next   = (sp1_reg == '0) ? air_reg : vox_rdata;
                state_next = ST_B_WR;
            end
            ST_B_WR: begin
                mask_we = 1'b1;
                if (cur_opaque == nxt_opaque) begin
                    mask_wdata = 6'd0;
                end else if (cur_opaque) begin
                    mask_wdata = {1'b1, 1'b0, cur_reg};
                end else begin
                    mask_wdata = {1'b1, 1'b1, nxt_code};
                end
                if (n_reg + NW'(1) == total) begin
                    n_next      = '0;
                    i_next      = '0;
                    j_next      = '0;
                    mvalid_next = 1'b1;
                    state_next  = ST_SC_ISSUE;
                end else begin
                    n_next = n_reg + NW'(1);
                    if (i_reg + CW'(1) == l1) begin
                        i_next = '0;
                        j_next = j_reg + CW'(1);
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                    state_next = ST_B_CUR;
                end
            end
            ST_SC_ISSUE: begin
                mask_raddr = n_reg[MAW-1:0];
                state_next = (n_reg == total) ? ST_NEXT : ST_SC_CHK;
            end
            ST_SC_CHK: begin
                if (!mask_rdata[CELL_FACE_BIT]) begin
                    n_next = n_reg + NW'(1);
                    if (i_reg + CW'(1) == l1) begin
                        i_next = '0;
                        j_next = j_reg + CW'(1);
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                    state_next = ST_SC_ISSUE;
                end else begin
                    cell_next  = mask_rdata;
                    n0_next    = n_reg;
                    i0_next    = i_reg;
                    j0_next    = j_reg;
                    w_next     = CW'(1);
                    state_next = ST_W_ISSUE;
                end
            end
            ST_W_ISSUE: begin
                mask_raddr = MAW'(n0_reg + NW'(w_reg));
                if (i_ext_sum < (CW+1)'(l1)) begin
                    state_next = ST_W_CHK;
                end else begin
                    h_next     = CW'(1);
                    rb_next    = n0_reg + NW'(l1);
                    s_next     = '0;
                    state_next = ST_H_ISSUE;
                end
            end
            ST_W_CHK: begin
                if (mask_rdata == cell_reg) begin
                    w_next     = w_reg + CW'(1);
                    state_next = ST_W_ISSUE;
                end else begin
                    h_next     = CW'(1);
                    rb_next    = n0_reg + NW'(l1);
                    s_next     = '0;
                    state_next = ST_H_ISSUE;
                end
            end
            ST_H_ISSUE: begin
                mask_raddr = MAW'(rb_reg + NW'(s_reg));
                if (j_ext_sum < (CW+1)'(l2)) begin
                    state_next = ST_H_CHK;
                end else begin
                    r_next     = '0;
                    s_next     = '0;
                    rb_next    = n0_reg;
                    state_next = ST_CL;
                end
            end
            ST_H_CHK: begin
                if (mask_rdata != cell_reg) begin
                    r_next     = '0;
                    s_next     = '0;
                    rb_next    = n0_reg;
                    state_next = ST_CL;
                end else if (s_reg + CW'(1) == w_reg) begin
                    s_next     = '0;
                    h_next     = h_reg + CW'(1);
                    rb_next    = rb_reg + NW'(l1);
                    state_next = ST_H_ISSUE;
                end else begin
                    s_next     = s_reg + CW'(1);
                    state_next = ST_H_ISSUE;
                end
            end
            ST_CL: begin
                // Clear the merged rectangle one cell per cycle.
                mask_we    = 1'b1;
                mask_waddr = MAW'(rb_reg + NW'(s_reg));
                mask_wdata = 6'd0;
                if (s_reg + CW'(1) == w_reg) begin
                    s_next = '0;
                    if (r_reg + CW'(1) == h_reg) begin
                        n_next = n0_reg + NW'(w_reg);
                        if (i_ext_sum == (CW+1)'(l1)) begin
                            i_next = '0;
                            j_next = j0_reg + CW'(1);
                        end else begin
                            i_next = CW'(i_ext_sum);
                            j_next = j0_reg;
                        end
                        state_next = ST_EMIT;
                    end else begin
                        r_next  = r_reg + CW'(1);
                        rb_next = rb_reg + NW'(l1);
                    end
                end else begin
                    s_next = s_reg + CW'(1);
                end
            end
            ST_NEXT: begin
                mvalid_next = 1'b0;
                n_next      = '0;
                i_next      = '0;
                j_next      = '0;
                if (sp1_reg == dim_a) begin
                    sp1_next  = '0;
                    axis_next = axis_reg + 2'd1;
                    if (axis_reg == AXIS_Z) begin
                        fin_next   = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_B_CUR;
                    end
                end else begin
                    sp1_next   = sp1_reg + CW'(1);
                    state_next = ST_B_CUR;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    if (fin_reg) begin
                        out_quad_next = '0;
                        out_done_next = 1'b1;
                    end else begin
                        out_quad_next.quad_axis   = axis_reg;
                        out_quad_next.face_sign   = cell_reg[CELL_NEG_BIT] ? SIGN_NEG : SIGN_POS;
                        out_quad_next.face_block  = cell_reg[3:0];
                        out_quad_next.origin_x    = 5'(ox);
                        out_quad_next.origin_y    = 5'(oy);
                        out_quad_next.origin_z    = 5'(oz);
                        out_quad_next.span_first  = 5'(w_reg);
                        out_quad_next.span_second = 5'(h_reg);
                        out_quad_next.vertex_base = vcount_reg;
                        out_done_next             = 1'b0;
                        vcount_next               = vcount_reg + VERTS_PER_QUAD;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            axis_reg      <= AXIS_X;
            sp1_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            mvalid_reg    <= 1'b0;
            vcount_reg    <= 16'd0;
            air_reg       <= 4'd1;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            sp1_reg       <= sp1_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            mvalid_reg    <= mvalid_next;
            vcount_reg    <= vcount_next;
            fin_reg       <= fin_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                air_reg <= cfg_wr_data;
            end
        end
        cell_reg     <= cell_next;
        n0_reg       <= n0_next;
        i0_reg       <= i0_next;
        j0_reg       <= j0_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        s_reg        <= s_next;
        r_reg        <= r_next;
        rb_reg       <= rb_next;
        cur_reg      <= cur_next;
        out_quad_reg <= out_quad_next;
        out_done_reg <= out_done_next;
    end

    assign m_valid = out_valid_reg;
    assign m_quad  = out_quad_reg;
    assign m_done  = out_done_reg;

endmodule

### rtl/voxel_greedy_mesher_core.sv
// Greedy mesher for one voxel chunk of 4-bit block codes.
// Input channel (s_axis): tuser selects the item kind, 0 writes one block at
// x, y, z with a code, 1 fetches the next quad of the mesh. Writes give no
// result; each fetch gives exactly one result item on m_axis.
// Result channel (m_axis): tdata carries the quad, tuser is set when the mesh
// is finished, and then all quad fields are zero.
// cfg_wr_en / cfg_wr_data set the code that counts as air (reset value 1).
// A write inside the chunk restarts the walk and the vertex count.
// A write is handled by the back end in its idle state. A fetch leaves the
// queue, builds the face mask of a slice when none is built (two voxel RAM
// reads and one mask write per cell), scans the mask cells, moves to the next
// slice when the scan runs out, compares cells while the rectangle grows,
// clears the merged cells and loads the output register; the reads of the
// voxel RAM and mask RAM are registered.
// A two-entry queue sits before the back end, so items are taken while a
// result waits. When the receiver stalls, the result holds in its output
// register and the back end waits before the next result.
// After reset the walk starts at the first axis with no face mask built.
module voxel_greedy_mesher_core
    import vgm_pkg::*;
#(
    parameter int SIZE_X = 16,
    parameter int SIZE_Y = 16,
    parameter int SIZE_Z = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [3:0]          cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // block_x[3:0], block_y[7:4], block_z[11:8], block_code[15:12]
    input  logic [15:0]         s_axis_tdata,
    // operation
    input  logic                s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // quad_axis[1:0], face_sign[3:2], face_block[7:4], origin_x[12:8],
    // origin_y[17:13], origin_z[22:18], span_first[27:23], span_second[32:28],
    // vertex_base[48:33], zeros above
    output logic [OutDataW-1:0] m_axis_tdata,
    // mesh_done
    output logic                m_axis_tuser
);

    logic  q_valid;
    req_t  q_item;
    logic  q_pop;
    quad_t quad;

    vgm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    vgm_back #(
        .SIZE_X (SIZE_X),
        .SIZE_Y (SIZE_Y),
        .SIZE_Z (SIZE_Z)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .m_quad      (quad),
        .m_done      (m_axis_tuser)
    );

    assign m_axis_tdata = OutDataW'(quad);

endmodule
